// File: hw/rtl/efws_pkg.sv
// Shared types, constants and helpers for the earliest-free worker scheduler.
package efws_pkg;

    localparam int MAX_WORKERS = 256;
    localparam int ADDR_W      = $clog2(MAX_WORKERS);
    localparam int WORKER_W    = 8;
    localparam int TIME_W      = 63;
    localparam int DUR_W       = 32;
    localparam int COUNT_W     = 9;

    localparam logic [TIME_W-1:0]  TIME_MAX  = {TIME_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_WORKERS);
    localparam logic [COUNT_W-1:0] COUNT_MIN = COUNT_W'(1);

    // one heap slot: free time, then worker number
    typedef struct packed {
        logic [TIME_W-1:0]   free_time;
        logic [WORKER_W-1:0] worker;
    } entry_t;

    // controller to heap memory
    typedef struct packed {
        logic              clear;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr_a;
        logic [ADDR_W-1:0] rd_addr_b;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        entry_t            wr_entry;
    } mem_req_t;

    // controller to output register
    typedef struct packed {
        logic                load;
        logic [WORKER_W-1:0] worker;
        logic [TIME_W-1:0]   start_time;
    } result_t;

    // strict heap order: earlier free time first, lower worker on ties
    function automatic logic entry_less(entry_t a, entry_t b);
        logic res;
        if (a.free_time != b.free_time)
            res = (a.free_time < b.free_time);
        else
            res = (a.worker < b.worker);
        return res;
    endfunction

endpackage

// File: hw/rtl/efws_heap_mem.sv
// Heap storage: one write port, two registered read ports, per-entry valid bits.
module efws_heap_mem (
    input  logic               clk,
    input  logic               rst_n,
    input  efws_pkg::mem_req_t req,
    output efws_pkg::entry_t   rd_a,
    output efws_pkg::entry_t   rd_b
);

    efws_pkg::entry_t                 mem [efws_pkg::MAX_WORKERS];
    logic [efws_pkg::MAX_WORKERS-1:0] valid_reg;

    efws_pkg::entry_t               q_a_reg;
    efws_pkg::entry_t               q_b_reg;
    logic                           v_a_reg;
    logic                           v_b_reg;
    logic [efws_pkg::ADDR_W-1:0]    addr_a_reg;
    logic [efws_pkg::ADDR_W-1:0]    addr_b_reg;

    // array write and registered reads
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_entry;
        end
        if (req.rd_en)
        begin
            q_a_reg    <= mem[req.rd_addr_a];
            q_b_reg    <= mem[req.rd_addr_b];
            v_a_reg    <= valid_reg[req.rd_addr_a];
            v_b_reg    <= valid_reg[req.rd_addr_b];
            addr_a_reg <= req.rd_addr_a;
            addr_b_reg <= req.rd_addr_b;
        end
    end

    // valid bits: cleared at reset and on a worker-count write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (req.clear)
        begin
            valid_reg <= '0;
        end
        else if (req.wr_en)
        begin
            valid_reg[req.wr_addr] <= 1'b1;
        end
    end

    // unwritten slot reads as time zero, worker equal to its index
    always_comb
    begin
        rd_a = v_a_reg ? q_a_reg :
               efws_pkg::entry_t'{free_time: '0,
                                  worker: efws_pkg::WORKER_W'(addr_a_reg)};
        rd_b = v_b_reg ? q_b_reg :
               efws_pkg::entry_t'{free_time: '0,
                                  worker: efws_pkg::WORKER_W'(addr_b_reg)};
    end

endmodule

// File: hw/rtl/efws_sift_ctrl.sv
// Job sequencer: root read, start-time result, free-time update and sift-down.
module efws_sift_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [efws_pkg::DUR_W-1:0]     in_duration,
    input  logic [efws_pkg::COUNT_W-1:0]   worker_count,
    input  logic                           cfg_clear,
    input  logic                           out_free,
    output efws_pkg::result_t              result,
    output efws_pkg::mem_req_t             mem_req,
    input  efws_pkg::entry_t               rd_a,
    input  efws_pkg::entry_t               rd_b
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROOT,
        S_SIFT
    } state_t;

    state_t                           state_reg, state_next;
    logic [efws_pkg::ADDR_W-1:0]      pos_reg, pos_next;
    logic [efws_pkg::DUR_W-1:0]       dur_reg, dur_next;
    efws_pkg::entry_t                 item_reg, item_next;

    logic [efws_pkg::TIME_W:0]        sum;
    logic [efws_pkg::TIME_W-1:0]      next_time;
    logic [efws_pkg::ADDR_W+1:0]      left_idx;
    logic [efws_pkg::ADDR_W+1:0]      right_idx;
    logic                             l_ok, r_ok;
    logic                             l_lt_i, r_lt_i, r_lt_l;
    logic                             take_l, take_r;
    logic [efws_pkg::ADDR_W:0]        child_l;

    // saturating free-time update of the root
    always_comb
    begin
        sum       = {1'b0, rd_a.free_time} + (efws_pkg::TIME_W+1)'(dur_reg);
        next_time = sum[efws_pkg::TIME_W] ? efws_pkg::TIME_MAX
                                          : sum[efws_pkg::TIME_W-1:0];
    end

    // child selection at the current level, compares run in parallel
    always_comb
    begin
        left_idx  = {1'b0, pos_reg, 1'b1};
        right_idx = left_idx + 1'b1;
        l_ok      = left_idx  < (efws_pkg::ADDR_W+2)'(worker_count);
        r_ok      = right_idx < (efws_pkg::ADDR_W+2)'(worker_count);
        l_lt_i    = efws_pkg::entry_less(rd_a, item_reg);
        r_lt_i    = efws_pkg::entry_less(rd_b, item_reg);
        r_lt_l    = efws_pkg::entry_less(rd_b, rd_a);
        take_l    = l_ok && l_lt_i;
        take_r    = r_ok && (take_l ? r_lt_l : r_lt_i);
    end

    // next-state and memory request
    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        dur_next   = dur_reg;
        item_next  = item_reg;
        in_ready   = 1'b0;
        result     = '0;
        mem_req    = '0;
        child_l    = '0;
        mem_req.clear = cfg_clear;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    dur_next          = in_duration;
                    mem_req.rd_en     = 1'b1;
                    mem_req.rd_addr_a = '0;
                    mem_req.rd_addr_b = '0;
                    state_next        = S_ROOT;
                end
            end
            S_ROOT:
            begin
                if (out_free)
                begin
                    result.load         = 1'b1;
                    result.worker       = rd_a.worker;
                    result.start_time   = rd_a.free_time;
                    item_next.free_time = next_time;
                    item_next.worker    = rd_a.worker;
                    pos_next            = '0;
                    mem_req.rd_en       = 1'b1;
                    mem_req.rd_addr_a   = efws_pkg::ADDR_W'(1);
                    mem_req.rd_addr_b   = efws_pkg::ADDR_W'(2);
                    state_next          = S_SIFT;
                end
            end
            S_SIFT:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = pos_reg;
                if (take_r || take_l)
                begin
                    // promote the smaller child, move down to its slot
                    mem_req.wr_entry = take_r ? rd_b : rd_a;
                    pos_next = take_r ? efws_pkg::ADDR_W'(right_idx)
                                      : efws_pkg::ADDR_W'(left_idx);
                    child_l  = {pos_next, 1'b1};
                    mem_req.rd_en     = 1'b1;
                    mem_req.rd_addr_a = efws_pkg::ADDR_W'(child_l);
                    mem_req.rd_addr_b = efws_pkg::ADDR_W'(child_l + 1'b1);
                end
                else
                begin
                    // item settles here
                    mem_req.wr_entry = item_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        dur_reg  <= dur_next;
        item_reg <= item_next;
    end

    // sifting position stays inside the heap
    a_pos_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SIFT |-> (efws_pkg::COUNT_W)'(pos_reg) < worker_count)
        else $error("sift position beyond worker count");

    // each further level moves strictly deeper
    a_pos_descends: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SIFT && state_next == S_SIFT |=> pos_reg > $past(pos_reg))
        else $error("sift did not move down");

    // an accepted job always reads the root next
    a_accept_root: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_ROOT)
        else $error("accepted job did not reach root read");

    // heap writes only happen while sifting
    a_write_sift: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.wr_en |-> state_reg == S_SIFT)
        else $error("heap written outside sift");

endmodule

// File: hw/rtl/earliest_free_worker_scheduler.sv
// Earliest-free worker scheduler: assigns each job to the worker that frees up first.
// An accepted job goes on to the root read; when the output register is free, the
// root entry loads into it and raises m_axis_tvalid; a held output word delays this.
// Each job runs accept, root read, then one sift step per level moved (up to 8 for
// 256 workers) and one to settle the entry; a new job waits until it has settled.
// Reset: worker count 1, all free times zero; valid bits clear at once (also on cfg).
module earliest_free_worker_scheduler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] job_duration
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [7:0] worker_number, [70:8] start_time, [71] zero
    input  logic        cfg_wr_en,
    input  logic [8:0]  cfg_wr_data
);

    logic [efws_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic                          out_valid_reg;
    logic [efws_pkg::WORKER_W-1:0] out_worker_reg;
    logic [efws_pkg::TIME_W-1:0]   out_time_reg;
    logic                          out_free;

    efws_pkg::result_t  result;
    efws_pkg::mem_req_t mem_req;
    efws_pkg::entry_t   rd_a;
    efws_pkg::entry_t   rd_b;

    // worker count written value, clamped to 1..MAX_WORKERS
    always_comb
    begin
        if (cfg_wr_data == '0)
            count_next = efws_pkg::COUNT_MIN;
        else if (cfg_wr_data > efws_pkg::COUNT_MAX)
            count_next = efws_pkg::COUNT_MAX;
        else
            count_next = cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= efws_pkg::COUNT_MIN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                count_reg <= count_next;
            if (result.load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // output word register
    always_ff @(posedge clk)
    begin
        if (result.load)
        begin
            out_worker_reg <= result.worker;
            out_time_reg   <= result.start_time;
        end
    end

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_time_reg, out_worker_reg};

    efws_sift_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_duration  (s_axis_tdata),
        .worker_count (count_reg),
        .cfg_clear    (cfg_wr_en),
        .out_free     (out_free),
        .result       (result),
        .mem_req      (mem_req),
        .rd_a         (rd_a),
        .rd_b         (rd_b)
    );

    efws_heap_mem u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rd_a  (rd_a),
        .rd_b  (rd_b)
    );

endmodule
